// ----- sv/dht_pkg.sv -----
// Package with constants, types and helper functions for the DH link transform core.
package dht_pkg;

  localparam int CordicSteps = 24;
  localparam int DataWidth   = 32;
  localparam int TableLen    = 30;
  localparam int NumSteps    = (CordicSteps < TableLen) ? CordicSteps : TableLen;
  localparam int AngW        = 26;
  localparam int CW          = 34;
  localparam int ZW          = 32;

  localparam logic signed [AngW:0] FullTurn    = 27'sd23592960;
  localparam logic signed [AngW:0] HalfTurn    = 27'sd11796480;
  localparam logic signed [AngW:0] QuarterTurn = 27'sd5898240;
  localparam logic signed [CW-1:0] CordicGain  = 34'sd652032874;
  localparam logic signed [CW-1:0] OneQ30      = 34'sd1073741824;
  localparam logic signed [63:0]   SatHi       = (DataWidth < 32) ?
      ((64'sd1 <<< (DataWidth - 1)) - 64'sd1) : 64'sd2147483647;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 neg;
  } cordic_t;

  typedef struct packed {
    logic signed [31:0] link_length;
    logic signed [31:0] link_offset;
  } side_t;

  function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
    logic signed [ZW-1:0] t [TableLen];
    t = '{32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485, 32'sd15000234,
          32'sd7507429, 32'sd3754631, 32'sd1877430, 32'sd938729, 32'sd469366,
          32'sd234683, 32'sd117342, 32'sd58671, 32'sd29335, 32'sd14668, 32'sd7334,
          32'sd3667, 32'sd1833, 32'sd917, 32'sd458, 32'sd229, 32'sd115, 32'sd57,
          32'sd29, 32'sd14, 32'sd7, 32'sd4, 32'sd2, 32'sd1, 32'sd0};
    return t[i];
  endfunction

  function automatic logic signed [31:0] clamp_q30(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    r = (v > OneQ30) ? OneQ30 : ((v < -OneQ30) ? -OneQ30 : v);
    return r[31:0];
  endfunction

  function automatic logic signed [63:0] mul_q30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return p >>> 30;
  endfunction

  function automatic logic signed [31:0] sat_tr(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v > SatHi) ? SatHi : ((v < -SatHi - 64'sd1) ? -SatHi - 64'sd1 : v);
    return r[31:0];
  endfunction

endpackage

// ----- sv/dht_angle_fold.sv -----
// Angle reduction modulo a full turn and fold into the CORDIC start vector.
module dht_angle_fold import dht_pkg::*; (
  input  logic signed [AngW-1:0] ang,
  output cordic_t                start
);
  logic signed [AngW:0] r0, r1, r2;
  always_comb begin
    r0 = 27'(ang);
    if (r0 >= HalfTurn) begin
      r1 = r0 - FullTurn;
    end else if (r0 < -HalfTurn) begin
      r1 = r0 + FullTurn;
    end else begin
      r1 = r0;
    end
    start.neg = 1'b0;
    if (r1 > QuarterTurn) begin
      r2 = r1 - HalfTurn;
      start.neg = 1'b1;
    end else if (r1 < -QuarterTurn) begin
      r2 = r1 + HalfTurn;
      start.neg = 1'b1;
    end else begin
      r2 = r1;
    end
    start.x = CordicGain;
    start.y = '0;
    start.z = ZW'(r2) <<< 6;
  end
endmodule

// ----- sv/dht_cordic_stage.sv -----
// One registered rotation step of the pipelined CORDIC, for both angles.
module dht_cordic_stage import dht_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  logic [4:0] step,
  input  cordic_t    a_in,
  input  cordic_t    t_in,
  output cordic_t    a_r,
  output cordic_t    t_r
);
  function automatic cordic_t rot(input cordic_t c);
    cordic_t o;
    logic signed [CW-1:0] dx, dy;
    dx = c.y >>> step;
    dy = c.x >>> step;
    o = c;
    if (c.z >= 0) begin
      o.x = c.x - dx;
      o.y = c.y + dy;
      o.z = c.z - atan_entry(step);
    end else begin
      o.x = c.x + dx;
      o.y = c.y - dy;
      o.z = c.z + atan_entry(step);
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= rot(a_in);
      t_r <= rot(t_in);
    end
  end
endmodule

// ----- sv/dh_link_transform_core.sv -----
// Top level of the DH link transform: angle fold, CORDIC pipeline, product and output stages.
//  channel | direction | ports
//  in_     | input     | in_valid, in_stall, in_twist_angle, in_link_length, in_link_offset,
//          |           | in_joint_angle
//  out_    | output    | out_valid, out_stall, out_r00..out_pz
// One transfer per cycle while in_stall is low; registers: start, CORDIC, clamp, output.
// The pipeline advances as a whole whenever the output register is empty or being taken.
// Reset clears only the valid bits; payload registers are not reset.
// A stall holds every stage, so nothing is lost or repeated.
module dh_link_transform_core import dht_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [25:0] in_twist_angle,
  input  logic signed [31:0] in_link_length,
  input  logic signed [31:0] in_link_offset,
  input  logic signed [25:0] in_joint_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_r00,
  output logic signed [31:0] out_r01,
  output logic signed [31:0] out_px,
  output logic signed [31:0] out_r10,
  output logic signed [31:0] out_r11,
  output logic signed [31:0] out_r12,
  output logic signed [31:0] out_py,
  output logic signed [31:0] out_r20,
  output logic signed [31:0] out_r21,
  output logic signed [31:0] out_r22,
  output logic signed [31:0] out_pz
);
  localparam int NV = NumSteps + 3;
  logic          en;
  logic [NV-1:0] vld_r;
  cordic_t       a_st_r, t_st_r;
  side_t         side_r [NumSteps+2];
  cordic_t       a_c [NumSteps+1];
  cordic_t       t_c [NumSteps+1];
  cordic_t       a_f, t_f;
  logic signed [31:0] sa_r, ca_r, st_r, ct_r;
  logic signed [63:0] m_ca_st, m_ca_ct, m_sa_st, m_sa_ct, m_d_sa, m_d_ca;

  assign en        = !(vld_r[NV-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld_r[NV-1];

  dht_angle_fold u_fa (.ang(in_twist_angle), .start(a_f));
  dht_angle_fold u_ft (.ang(in_joint_angle), .start(t_f));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NV-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_st_r <= a_f;
      t_st_r <= t_f;
      side_r[0] <= '{link_length: in_link_length, link_offset: in_link_offset};
      for (int k = 1; k < NumSteps + 2; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign a_c[0] = a_st_r;
  assign t_c[0] = t_st_r;

  for (genvar g = 0; g < NumSteps; g++) begin : g_cordic
    dht_cordic_stage u_stage (
      .clk(clk), .en(en), .step(5'(g)), .a_in(a_c[g]), .t_in(t_c[g]), .a_r(a_c[g+1]),
      .t_r(t_c[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ca_r <= clamp_q30(a_c[NumSteps].neg ? -a_c[NumSteps].x : a_c[NumSteps].x);
      sa_r <= clamp_q30(a_c[NumSteps].neg ? -a_c[NumSteps].y : a_c[NumSteps].y);
      ct_r <= clamp_q30(t_c[NumSteps].neg ? -t_c[NumSteps].x : t_c[NumSteps].x);
      st_r <= clamp_q30(t_c[NumSteps].neg ? -t_c[NumSteps].y : t_c[NumSteps].y);
    end
  end

  always_comb begin
    m_ca_st = mul_q30(ca_r, st_r);
    m_ca_ct = mul_q30(ca_r, ct_r);
    m_sa_st = mul_q30(sa_r, st_r);
    m_sa_ct = mul_q30(sa_r, ct_r);
    m_d_sa  = mul_q30(side_r[NumSteps+1].link_offset, sa_r);
    m_d_ca  = mul_q30(side_r[NumSteps+1].link_offset, ca_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r00 <= ct_r;
      out_r01 <= -st_r;
      out_px  <= side_r[NumSteps+1].link_length;
      out_r10 <= m_ca_st[31:0];
      out_r11 <= m_ca_ct[31:0];
      out_r12 <= -sa_r;
      out_py  <= sat_tr(-m_d_sa);
      out_r20 <= m_sa_st[31:0];
      out_r21 <= m_sa_ct[31:0];
      out_r22 <= ca_r;
      out_pz  <= sat_tr(m_d_ca);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_r00) && $stable(out_pz))
    else $error("Stalled result changed.");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("Input stalled without output back-pressure.");
  a_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_r00 <= 32'sd1073741824) && (out_r00 >= -32'sd1073741824))
    else $error("Cosine out of range.");
endmodule
